/* design/spot_pkg.sv */
// Shared types and constants for the sorted protocol owner table.
// Holds the command codes, status codes, controller states, table entry layout and the
// command and status bundles between controller and datapath.
package spot_pkg;

  localparam int KEY_W               = 32;
  localparam int GID_W               = 4;
  localparam int COUNT_OUT_W         = 7;
  localparam int DEFAULT_TABLE_DEPTH = 64;

  // Command codes of the input transaction
  typedef enum logic [1:0] {
    CMD_LOOKUP     = 2'd0,
    CMD_ADD        = 2'd1,
    CMD_REMOVE     = 2'd2,
    CMD_REMOVE_ALL = 2'd3
  } cmd_t;

  // Result status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_OWNED = 2'd2;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROBE,
    ST_CHECK,
    ST_DECIDE,
    ST_MOVE,
    ST_FINISH
  } state_t;

  // One table entry
  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [GID_W-1:0]        owner;
  } entry_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;      // latch the input transaction, open the search range
    logic probe;     // read the middle entry of the search range
    logic check;     // compare the probed entry and narrow the range
    logic mv_setup;  // prepare pointers for a shift or compaction
    logic mv_step;   // one read and at most one write of the move engine
    logic finish;    // final write, count update, load the result register
  } ctrl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic search_open;  // search range not empty and command is not remove-all
    logic key_eq;       // probed entry matches the key
    logic need_move;    // command needs a shift or compaction
    logic moves_done;   // move engine has drained
    logic out_free;     // result register can take a new result
  } dp_status_t;

endpackage

/* design/spot_ctrl.sv */
// Controller state machine of the sorted protocol owner table.
// Sequences search, move and finish steps; depends on spot_pkg.
module spot_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  spot_pkg::dp_status_t   sts,
  output spot_pkg::ctrl_cmd_t    ctrl
);
  import spot_pkg::*;

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    ctrl       = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctrl.load  = 1'b1;
          state_next = ST_PROBE;
        end
      end
      ST_PROBE: begin
        ctrl.probe = 1'b1;
        state_next = sts.search_open ? ST_CHECK : ST_DECIDE;
      end
      ST_CHECK: begin
        ctrl.check = 1'b1;
        state_next = sts.key_eq ? ST_DECIDE : ST_PROBE;
      end
      ST_DECIDE: begin
        if (sts.need_move) begin
          ctrl.mv_setup = 1'b1;
          state_next    = ST_MOVE;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_MOVE: begin
        ctrl.mv_step = 1'b1;
        if (sts.moves_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // Hold until the result register is free
        if (sts.out_free) begin
          ctrl.finish = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

/* design/spot_datapath.sv */
// Datapath of the sorted protocol owner table: entry memory, search
// registers, move engine and result register. Depends on spot_pkg.
module spot_datapath #(
  parameter int TABLE_DEPTH = spot_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst,
  input  spot_pkg::ctrl_cmd_t                ctrl,
  output spot_pkg::dp_status_t               sts,
  input  spot_pkg::cmd_t                     in_cmd,
  input  logic signed [spot_pkg::KEY_W-1:0]  in_key,
  input  logic [spot_pkg::GID_W-1:0]         in_gid,
  input  logic                               out_ready,
  output logic                               out_valid,
  output logic                               found,
  output logic [spot_pkg::GID_W-1:0]         owner_id,
  output logic [1:0]                         status,
  output logic [spot_pkg::COUNT_OUT_W-1:0]   entry_count
);
  import spot_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  entry_t                  mem [TABLE_DEPTH];
  entry_t                  rd_data;

  cmd_t                    cmd_q;
  logic signed [KEY_W-1:0] key_q;
  logic [GID_W-1:0]        gid_q;
  logic [CW-1:0]           used_count;
  logic [CW-1:0]           lo;
  logic [CW-1:0]           hi;
  logic [CW-1:0]           mid_q;
  logic [CW-1:0]           pos;
  logic [CW-1:0]           moves_left;
  logic [CW-1:0]           rp;
  logic [CW-1:0]           wp;
  logic                    hit;
  logic [GID_W-1:0]        hit_owner;
  logic                    pv;

  logic [CW-1:0]           mid;
  logic [CW-1:0]           count_next;
  logic                    key_gt;
  logic                    full;
  logic                    owner_match;
  logic                    dir_up;
  logic                    keep;
  logic                    mv_write;
  logic                    ins_write;
  logic                    wr_en;
  logic [AW-1:0]           wr_addr;
  logic [AW-1:0]           rd_addr;
  entry_t                  wr_data;
  logic [1:0]              res_status;

  // Search and decision terms
  always_comb begin
    mid         = lo + ((hi - lo) >> 1);
    key_gt      = rd_data.key > key_q;
    full        = used_count == CW'(TABLE_DEPTH);
    owner_match = hit_owner == gid_q;
    dir_up      = cmd_q == CMD_ADD;
    keep        = (cmd_q != CMD_REMOVE_ALL) || (rd_data.owner != gid_q);

    sts.search_open = (lo < hi) && (cmd_q != CMD_REMOVE_ALL);
    sts.key_eq      = rd_data.key == key_q;
    sts.need_move   = (cmd_q == CMD_ADD && !hit && !full) ||
                      (cmd_q == CMD_REMOVE && hit && owner_match) ||
                      (cmd_q == CMD_REMOVE_ALL);
    sts.moves_done  = (moves_left == '0) && !pv;
    sts.out_free    = !out_valid || out_ready;
  end

  // Memory port selection
  always_comb begin
    mv_write  = ctrl.mv_step && pv && keep;
    ins_write = ctrl.finish && (cmd_q == CMD_ADD) && (hit || !full);
    wr_en     = mv_write || ins_write;
    wr_addr   = mv_write ? wp[AW-1:0] : pos[AW-1:0];
    wr_data   = mv_write ? rd_data : entry_t'{key: key_q, owner: gid_q};
    rd_addr   = ctrl.probe ? mid[AW-1:0] : rp[AW-1:0];
  end

  // Count and status after the command
  always_comb begin
    count_next = used_count;
    res_status = STATUS_OK;
    case (cmd_q)
      CMD_ADD: begin
        if (!hit) begin
          if (full) begin
            res_status = STATUS_FULL;
          end else begin
            count_next = used_count + CW'(1);
          end
        end
      end
      CMD_REMOVE: begin
        if (hit) begin
          if (owner_match) begin
            count_next = used_count - CW'(1);
          end else begin
            res_status = STATUS_OWNED;
          end
        end
      end
      CMD_REMOVE_ALL: begin
        count_next = wp;
      end
      default: begin
        count_next = used_count;
      end
    endcase
  end

  // Entry memory with registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      used_count <= '0;
      hit        <= 1'b0;
      pv         <= 1'b0;
      moves_left <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (ctrl.load) begin
        hit <= 1'b0;
      end else if (ctrl.check && sts.key_eq) begin
        hit <= 1'b1;
      end

      // Set the number of reads for the move
      if (ctrl.mv_setup) begin
        pv <= 1'b0;
        case (cmd_q)
          CMD_ADD:    moves_left <= used_count - pos;
          CMD_REMOVE: moves_left <= used_count - pos - CW'(1);
          default:    moves_left <= used_count;
        endcase
      end else if (ctrl.mv_step) begin
        pv <= moves_left != '0;
        if (moves_left != '0) begin
          moves_left <= moves_left - CW'(1);
        end
      end

      if (ctrl.finish) begin
        used_count <= count_next;
      end

      if (ctrl.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    // Latch the transaction and open the search range
    if (ctrl.load) begin
      cmd_q <= in_cmd;
      key_q <= in_key;
      gid_q <= in_gid;
      lo    <= '0;
      hi    <= used_count;
    end

    // Probe the middle, or record the insertion point on a miss
    if (ctrl.probe) begin
      mid_q <= mid;
      if (!sts.search_open) begin
        pos <= lo;
      end
    end

    // Narrow the range or take the hit
    if (ctrl.check) begin
      if (sts.key_eq) begin
        pos       <= mid_q;
        hit_owner <= rd_data.owner;
      end else if (key_gt) begin
        hi <= mid_q;
      end else begin
        lo <= mid_q + CW'(1);
      end
    end

    // Move engine pointers
    if (ctrl.mv_setup) begin
      case (cmd_q)
        CMD_ADD: begin
          rp <= used_count - CW'(1);
          wp <= used_count;
        end
        CMD_REMOVE: begin
          rp <= pos + CW'(1);
          wp <= pos;
        end
        default: begin
          rp <= '0;
          wp <= '0;
        end
      endcase
    end else if (ctrl.mv_step) begin
      if (moves_left != '0) begin
        rp <= dir_up ? rp - CW'(1) : rp + CW'(1);
      end
      if (mv_write) begin
        wp <= dir_up ? wp - CW'(1) : wp + CW'(1);
      end
    end

    // Result register
    if (ctrl.finish) begin
      found       <= hit;
      owner_id    <= (cmd_q == CMD_LOOKUP && hit) ? hit_owner : '0;
      status      <= res_status;
      entry_count <= COUNT_OUT_W'(count_next);
    end
  end

endmodule

/* design/sorted_protocol_owner_table.sv */
// Top level of the sorted protocol owner table.
// Instantiates spot_ctrl and spot_datapath; depends on spot_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready) carries cmd, protocol_key, game_id.
//   Output channel (out_valid/out_ready) carries found, owner_id, status,
//   entry_count: exactly one result transaction per input transaction.
//   Entries sit in one memory with a registered read port, kept sorted by
//   signed key. One transaction is worked on at a time.
// Operation, with n entries in use:
//   search: binary search, up to ceil(log2(n+1)) key compares;
//   lookup or owner change: search only, no entries move;
//   insert or remove: search, then shift the entries behind the key;
//   remove-all: no search, one memory read per entry, kept ones compacted.
//   The move engine reads one entry each cycle and writes at most one.
// Reset: rst clears the entry count; no memory clearing pass is needed.
// Stall: a finished result waits in the output register; the next
//   transaction is accepted and searched meanwhile, and only its final
//   step waits until the receiver takes the pending result.
module sorted_protocol_owner_table #(
  parameter int TABLE_DEPTH = spot_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         cmd,
  input  logic signed [spot_pkg::KEY_W-1:0]  protocol_key,
  input  logic [spot_pkg::GID_W-1:0]         game_id,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               found,
  output logic [spot_pkg::GID_W-1:0]         owner_id,
  output logic [1:0]                         status,
  output logic [spot_pkg::COUNT_OUT_W-1:0]   entry_count
);
  import spot_pkg::*;

  ctrl_cmd_t  ctrl;
  dp_status_t sts;

  // Sequencer
  spot_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .ctrl     (ctrl)
  );

  // Table storage and arithmetic
  spot_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .sts         (sts),
    .in_cmd      (cmd_t'(cmd)),
    .in_key      (protocol_key),
    .in_gid      (game_id),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .found       (found),
    .owner_id    (owner_id),
    .status      (status),
    .entry_count (entry_count)
  );

  // At most one datapath operation per cycle
  a_one_op: assert property (@(posedge clk) disable iff (rst)
    $onehot0(ctrl))
    else $error("more than one datapath command active");

  // Busy right after an accepted transaction
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready right after accepting a transaction");

  // Never overwrite a result the receiver has not taken
  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    ctrl.finish |-> (!out_valid || out_ready))
    else $error("result overwritten while stalled");

  // Full only on a miss, owned-by-other only on a hit
  a_status_found: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!(status == STATUS_FULL && found) &&
                   !(status == STATUS_OWNED && !found)))
    else $error("status inconsistent with found flag");

endmodule
